@@ design/eoq_pkg.sv @@
// Shared types, constants and codes for the elevator order queue.
`default_nettype none
package eoq_pkg;

  // Building and queue sizes.
  localparam int FLOORS      = 4;
  localparam int CABIN_DEPTH = 4;
  localparam int HALL_DEPTH  = 6;

  // Derived widths of the stored entries and the length counters.
  localparam int FLOOR_W    = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int HALL_W     = FLOOR_W + 1;
  localparam int CAB_LEN_W  = $clog2(CABIN_DEPTH + 1);
  localparam int HALL_LEN_W = $clog2(HALL_DEPTH + 1);

  // Fixed widths of the interface fields.
  localparam int REQ_W    = 2;
  localparam int FLOOR_IN_W = 3;
  localparam int DIR_W    = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 3;
  localparam int HEAD_W   = 2;

  // Raw direction codes of the two's complement direction field.
  localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_CAB  = 2'd0,
    REQ_DEL_CAB  = 2'd1,
    REQ_INS_HALL = 2'd2,
    REQ_DEL_HALL = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 3'd0,
    ST_RANGE    = 3'd1,
    ST_DIR      = 3'd2,
    ST_DUP      = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_APPLY = 4'b0100,
    S_SEND  = 4'b1000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic match;
    logic apply;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

@@ design/eoq_ctrl.sv @@
// Sequencer that steps one request through check, update and result.
`default_nettype none
module eoq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  eoq_pkg::sts_t sts,
  output eoq_pkg::cmd_t cmd
);
  import eoq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.match  = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule
`default_nettype wire

@@ design/eoq_dp.sv @@
// Queue storage, match logic, request checks and the output register.
`default_nettype none
module eoq_dp (
  input  logic                                    clk,
  input  logic                                    rst,
  input  eoq_pkg::cmd_t                           cmd,
  output eoq_pkg::sts_t                           sts,
  input  logic        [eoq_pkg::REQ_W-1:0]        req_type,
  input  logic        [eoq_pkg::FLOOR_IN_W-1:0]   floor,
  input  logic signed [eoq_pkg::DIR_W-1:0]        direction,
  input  logic                                    out_stall,
  output logic                                    out_valid,
  output logic        [eoq_pkg::STATUS_W-1:0]     status,
  output logic        [eoq_pkg::COUNT_W-1:0]      cabin_count,
  output logic        [eoq_pkg::COUNT_W-1:0]      hall_count,
  output logic        [eoq_pkg::HEAD_W-1:0]       cabin_head_floor,
  output logic        [eoq_pkg::HEAD_W-1:0]       hall_head_floor,
  output logic                                    hall_head_up
);
  import eoq_pkg::*;

  req_t                  req_q;
  logic [FLOOR_IN_W-1:0] floor_q;
  logic [DIR_W-1:0]      dir_q;

  logic [FLOOR_W-1:0]    cab_q  [CABIN_DEPTH];
  logic [HALL_W-1:0]     hall_q [HALL_DEPTH];
  logic [CAB_LEN_W-1:0]  cab_len;
  logic [HALL_LEN_W-1:0] hall_len;

  logic [CABIN_DEPTH-1:0] cab_match;
  logic [HALL_DEPTH-1:0]  hall_match;
  logic [CABIN_DEPTH-1:0] cab_after;
  logic [HALL_DEPTH-1:0]  hall_after;

  status_t res_status;
  status_t st_next;
  logic    app_cab, rem_cab, app_hall, rem_hall;

  logic               in_range, dir_ok, up, on_edge;
  logic [FLOOR_W-1:0] cab_key;
  logic [HALL_W-1:0]  hall_key;
  logic               cab_hit, hall_hit, cab_full, hall_full;

  assign in_range = {1'b0, floor_q} < (FLOOR_IN_W + 1)'(FLOORS);
  assign dir_ok   = (dir_q == DIR_UP) || (dir_q == DIR_DOWN);
  assign up       = (dir_q == DIR_UP);
  assign cab_key  = floor_q[FLOOR_W-1:0];
  assign hall_key = {cab_key, up};
  assign on_edge  = (up && ({1'b0, floor_q} == (FLOOR_IN_W + 1)'(FLOORS - 1))) ||
                    (!up && (floor_q == '0));

  assign cab_hit   = |cab_match;
  assign hall_hit  = |hall_match;
  assign cab_full  = cab_len >= CAB_LEN_W'(CABIN_DEPTH);
  assign hall_full = hall_len >= HALL_LEN_W'(HALL_DEPTH);

  // An entry shifts forward when the removed entry sits at or below it.
  always_comb begin
    for (int i = 0; i < CABIN_DEPTH; i++) begin
      cab_after[i] = |(cab_match & ({CABIN_DEPTH{1'b1}} >> (CABIN_DEPTH - 1 - i)));
    end
    for (int i = 0; i < HALL_DEPTH; i++) begin
      hall_after[i] = |(hall_match & ({HALL_DEPTH{1'b1}} >> (HALL_DEPTH - 1 - i)));
    end
  end

  // Request checks in the order the status codes take priority.
  always_comb begin
    st_next  = ST_DONE;
    app_cab  = 1'b0;
    rem_cab  = 1'b0;
    app_hall = 1'b0;
    rem_hall = 1'b0;
    case (req_q)
      REQ_INS_CAB: begin
        if (!in_range)     st_next = ST_RANGE;
        else if (cab_hit)  st_next = ST_DUP;
        else if (cab_full) st_next = ST_FULL;
        else               app_cab = 1'b1;
      end
      REQ_DEL_CAB: begin
        if (cab_len == '0)  st_next = ST_EMPTY;
        else if (!in_range) st_next = ST_RANGE;
        else if (!cab_hit)  st_next = ST_NOTFOUND;
        else                rem_cab = 1'b1;
      end
      REQ_INS_HALL: begin
        if (!in_range)      st_next = ST_RANGE;
        else if (!dir_ok)   st_next = ST_DIR;
        else if (on_edge)   st_next = ST_DIR;
        else if (hall_hit)  st_next = ST_DUP;
        else if (hall_full) st_next = ST_FULL;
        else                app_hall = 1'b1;
      end
      REQ_DEL_HALL: begin
        if (hall_len == '0) st_next = ST_EMPTY;
        else if (!in_range) st_next = ST_RANGE;
        else if (!dir_ok)   st_next = ST_DIR;
        else if (!hall_hit) st_next = ST_NOTFOUND;
        else                rem_hall = 1'b1;
      end
      default: begin
        st_next = ST_DONE;
      end
    endcase
  end

  // Request latch, match vectors and result status.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q   <= req_t'(req_type);
      floor_q <= floor;
      dir_q   <= direction;
    end
    if (cmd.match) begin
      for (int i = 0; i < CABIN_DEPTH; i++) begin
        cab_match[i] <= (CAB_LEN_W'(i) < cab_len) && (cab_q[i] == cab_key);
      end
      for (int i = 0; i < HALL_DEPTH; i++) begin
        hall_match[i] <= (HALL_LEN_W'(i) < hall_len) && (hall_q[i] == hall_key);
      end
    end
    if (cmd.apply) begin
      res_status <= st_next;
    end
  end

  // Entry storage: append at the tail or close the gap of a removed entry.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CABIN_DEPTH; i++) begin
      if (cmd.apply && app_cab && (CAB_LEN_W'(i) == cab_len)) begin
        cab_q[i] <= cab_key;
      end else if (cmd.apply && rem_cab && cab_after[i]) begin
        cab_q[i] <= cab_q[(i + 1 < CABIN_DEPTH) ? i + 1 : i];
      end
    end
    for (int i = 0; i < HALL_DEPTH; i++) begin
      if (cmd.apply && app_hall && (HALL_LEN_W'(i) == hall_len)) begin
        hall_q[i] <= hall_key;
      end else if (cmd.apply && rem_hall && hall_after[i]) begin
        hall_q[i] <= hall_q[(i + 1 < HALL_DEPTH) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cab_len  <= '0;
      hall_len <= '0;
    end else if (cmd.apply) begin
      if (app_cab)       cab_len  <= cab_len + CAB_LEN_W'(1);
      else if (rem_cab)  cab_len  <= cab_len - CAB_LEN_W'(1);
      if (app_hall)      hall_len <= hall_len + HALL_LEN_W'(1);
      else if (rem_hall) hall_len <= hall_len - HALL_LEN_W'(1);
    end
  end

  // Output register; it takes a new result only when the last one has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status           <= res_status;
      cabin_count      <= COUNT_W'(cab_len);
      hall_count       <= COUNT_W'(hall_len);
      cabin_head_floor <= (cab_len != '0) ? HEAD_W'(cab_q[0]) : '0;
      hall_head_floor  <= (hall_len != '0) ? HEAD_W'(hall_q[0][HALL_W-1:1]) : '0;
      hall_head_up     <= (hall_len != '0) ? hall_q[0][0] : 1'b0;
    end
  end

  assign sts.out_busy = out_valid && out_stall;

endmodule
`default_nettype wire

@@ design/elevator_order_queue_core.sv @@
// Top level of the elevator order queue: controller, datapath and checks.
//
// The block keeps two arrival-ordered queues of elevator orders: a cabin
// queue of floors and a hall queue of floor-and-direction calls. Each input
// beat carries one request (insert or delete, cabin or hall) with a floor
// and, for hall requests, a direction. Each request produces exactly one
// output beat with a status code, both queue counts and both queue heads as
// they stand after the request.
// Both channels use valid and stall; a beat moves on a rising edge where
// valid is high and stall is low. The block works on one request at a time:
// after a beat is taken, the three sequencer steps register the parallel
// match of the key against every held entry, check the request and append
// or shift the queue, and load the output register. No new beat is taken
// until the result is loaded. A result held by out_stall keeps its payload
// steady; the block then finishes the next request and waits in its last
// step until the output register frees.
// A synchronous reset empties both queues and drops out_valid.
`default_nettype none
module elevator_order_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  floor,
  input  logic signed [1:0] direction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [2:0]  cabin_count,
  output logic [2:0]  hall_count,
  output logic [1:0]  cabin_head_floor,
  output logic [1:0]  hall_head_floor,
  output logic        hall_head_up
);
  import eoq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The sequencer owns the input handshake and the order of the steps.
  eoq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds both queues and the output register.
  eoq_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .req_type         (req_type),
    .floor            (floor),
    .direction        (direction),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .status           (status),
    .cabin_count      (cabin_count),
    .hall_count       (hall_count),
    .cabin_head_floor (cabin_head_floor),
    .hall_head_floor  (hall_head_floor),
    .hall_head_up     (hall_head_up)
  );

  // An accepted beat is always followed by the match step.
  a_accept_then_match: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> cmd.match)
    else $error("match step did not follow an accepted beat");

  // A new result never overwrites one that the receiver still holds off.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("output register loaded while stalled");

  // Reported counts never exceed the queue depths.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((4'(cabin_count) <= 4'(CABIN_DEPTH)) &&
                   (4'(hall_count) <= 4'(HALL_DEPTH))))
    else $error("queue count beyond its depth");

  // Only one request is in flight: no beat is taken while a step runs.
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (cmd.match || cmd.apply) |-> in_stall)
    else $error("input taken while a request is in progress");

endmodule
`default_nettype wire
